>>> sv/csb_pkg.sv
// Package for the cursor sequence buffer.
// Holds request/result types, command and status codes and default sizes.
// No dependencies.
package csb_pkg;

  localparam int unsigned CAPACITY_DEF   = 32;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned KIND_W  = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned STAT_W  = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_START   = 3'd0,
    KIND_ADVANCE = 3'd1,
    KIND_INSERT  = 3'd2,
    KIND_ATTACH  = 3'd3,
    KIND_REMOVE  = 3'd4,
    KIND_READ    = 3'd5
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_NOCUR = 2'd2
  } status_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] item_value;
  } csb_in_t;

  typedef struct packed {
    logic [VALUE_W-1:0] current_value;
    logic               has_current;
    logic [COUNT_W-1:0] item_count;
    logic [STAT_W-1:0]  status;
  } csb_out_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic report;
  } csb_ctl_t;

endpackage

>>> sv/cursor_sequence_buffer_unit.sv
// Top level of the cursor sequence buffer.
// Joins the controller and the datapath; depends on csb_pkg, csb_ctrl and csb_datapath.
//
// Usage:
//   Request channel: drive in_req and raise start; the request is taken at a
//   rising edge where start is high and busy is low. busy stays high until
//   the result has been captured.
//   Result channel: out_valid is high for exactly one cycle and out_rsp holds
//   the result in that cycle. The receiver cannot stall; it must take the
//   result in that cycle.
//   Sequence: the request is registered in the load step, the execute step
//   updates cursor, fill and status with the parallel cell shift, and the
//   report step registers the read of the cursor cell with the strobe. The
//   block takes no new request while busy; busy drops in the strobe cycle,
//   so the next request may be taken then.
//   Reset (rst_n low, synchronous): cursor and fill go to zero, the
//   controller goes idle and no strobe is pending. Entry cells are not
//   cleared; only entries below the fill count are ever read.
module cursor_sequence_buffer_unit #(
  parameter int unsigned CAPACITY   = csb_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = csb_pkg::DATA_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  csb_pkg::csb_in_t  in_req,
  output logic              out_valid,
  output csb_pkg::csb_out_t out_rsp
);

  csb_pkg::csb_ctl_t ctl;

  csb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .ctl       (ctl)
  );

  csb_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

endmodule

>>> sv/csb_ctrl.sv
// Controller for the cursor sequence buffer.
// Sequences each request through load, execute and report; drives busy and the strobe.
// Depends on csb_pkg.
module csb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  output csb_pkg::csb_ctl_t ctl
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_EXEC   = 3'b010,
    ST_REPORT = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    ctl           = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctl.exec  = 1'b1;
        state_nxt = ST_REPORT;
      end
      ST_REPORT: begin
        ctl.report    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> sv/csb_datapath.sv
// Datapath for the cursor sequence buffer.
// Holds the entry cells, cursor and fill; every cell shifts, holds or loads in parallel.
// Depends on csb_pkg.
module csb_datapath #(
  parameter int unsigned CAPACITY   = csb_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = csb_pkg::DATA_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  csb_pkg::csb_ctl_t ctl,
  input  csb_pkg::csb_in_t  in_req,
  output csb_pkg::csb_out_t out_rsp
);

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned XW   = (DATA_WIDTH > csb_pkg::VALUE_W) ? DATA_WIDTH : csb_pkg::VALUE_W;
  localparam int unsigned FW   = (CW > csb_pkg::COUNT_W) ? CW : csb_pkg::COUNT_W;

  csb_pkg::csb_in_t  req_r;
  csb_pkg::csb_out_t rsp_r;
  logic [DATA_WIDTH-1:0] cells_r [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_lo [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_hi [CAPACITY];
  logic [CW-1:0] cursor_r, cursor_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] pos;
  logic [csb_pkg::STAT_W-1:0] status_r, status_nxt;
  logic have, full, do_ins, do_rem;
  logic [XW-1:0] val_ext, cur_ext;
  logic [FW-1:0] fill_ext;
  logic [DATA_WIDTH-1:0] dval;

  assign val_ext = XW'(req_r.item_value);
  assign dval    = val_ext[DATA_WIDTH-1:0];
  assign have    = (cursor_r < fill_r);
  assign full    = (fill_r == CW'(CAPACITY));

  always_comb begin
    cursor_nxt = cursor_r;
    fill_nxt   = fill_r;
    status_nxt = csb_pkg::STAT_OK;
    pos        = cursor_r;
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    case (req_r.kind)
      csb_pkg::KIND_START: begin
        cursor_nxt = '0;
      end
      csb_pkg::KIND_ADVANCE: begin
        if (!have) begin
          status_nxt = csb_pkg::STAT_NOCUR;
        end else begin
          cursor_nxt = cursor_r + CW'(1);
        end
      end
      csb_pkg::KIND_INSERT: begin
        pos = have ? cursor_r : '0;
        if (full) begin
          status_nxt = csb_pkg::STAT_FULL;
        end else begin
          do_ins     = 1'b1;
          cursor_nxt = pos;
          fill_nxt   = fill_r + CW'(1);
        end
      end
      csb_pkg::KIND_ATTACH: begin
        pos = have ? (cursor_r + CW'(1)) : fill_r;
        if (full) begin
          status_nxt = csb_pkg::STAT_FULL;
        end else begin
          do_ins     = 1'b1;
          cursor_nxt = pos;
          fill_nxt   = fill_r + CW'(1);
        end
      end
      csb_pkg::KIND_REMOVE: begin
        if (!have) begin
          status_nxt = csb_pkg::STAT_NOCUR;
        end else begin
          do_rem   = 1'b1;
          fill_nxt = fill_r - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i > 0) begin : g_lo
      assign cell_lo[i] = cells_r[i-1];
    end else begin : g_lo0
      assign cell_lo[i] = cells_r[i];
    end
    if (i + 1 < CAPACITY) begin : g_hi
      assign cell_hi[i] = cells_r[i+1];
    end else begin : g_hi0
      assign cell_hi[i] = cells_r[i];
    end

    always_ff @(posedge clk) begin
      if (ctl.exec) begin
        if (do_ins) begin
          if (CW'(i) == pos) begin
            cells_r[i] <= dval;
          end else if (CW'(i) > pos) begin
            cells_r[i] <= cell_lo[i];
          end
        end else if (do_rem && (CW'(i) >= cursor_r)) begin
          cells_r[i] <= cell_hi[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      fill_r   <= '0;
    end else if (ctl.exec) begin
      cursor_r <= cursor_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_r <= in_req;
    end
    if (ctl.exec) begin
      status_r <= status_nxt;
    end
  end

  assign cur_ext  = XW'(cells_r[cursor_r[IW-1:0]]);
  assign fill_ext = FW'(fill_r);

  always_ff @(posedge clk) begin
    if (ctl.report) begin
      rsp_r.current_value <= have ? cur_ext[csb_pkg::VALUE_W-1:0] : '0;
      rsp_r.has_current   <= have;
      rsp_r.item_count    <= fill_ext[csb_pkg::COUNT_W-1:0];
      rsp_r.status        <= status_r;
    end
  end

  assign out_rsp = rsp_r;

endmodule

>>> sv/csb_checker.sv
// Port-level checks for the cursor sequence buffer.
// Bound to cursor_sequence_buffer_unit; depends on csb_pkg.
module csb_checker #(
  parameter int unsigned CAPACITY = csb_pkg::CAPACITY_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input csb_pkg::csb_out_t out_rsp
);

  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after request");

  a_req_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("result strobe missing three cycles after request");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result strobe outside end of request");

  a_no_current: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_rsp.has_current) |-> (out_rsp.current_value == '0))
    else $error("current value nonzero with no current item");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_rsp.item_count <= csb_pkg::COUNT_W'(CAPACITY)) &&
                   (out_rsp.status != 2'd3)))
    else $error("result count or status out of range");

endmodule

bind cursor_sequence_buffer_unit csb_checker #(
  .CAPACITY (CAPACITY)
) u_csb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);
